FILE: hw/rtl/c8ie_pkg.sv
// ============================================================================
// c8ie_pkg: shared definitions for the CHIP-8 execute unit
// Holds the beat payload types, opcode field codes, the ALU interface types
// and the sizing constants of the return stack.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package c8ie_pkg;

    // Return stack sizing. The level counter must be able to hold the depth itself.
    localparam int STACK_DEPTH = 16;
    localparam int STK_IDX_W   = $clog2(STACK_DEPTH);
    localparam int STK_LVL_W   = $clog2(STACK_DEPTH + 1);

    typedef logic [STK_IDX_W-1:0] stk_idx_t;
    typedef logic [STK_LVL_W-1:0] stk_lvl_t;

    localparam int NUM_REGS = 16;
    localparam logic [3:0] REG_V0 = 4'h0;
    localparam logic [3:0] REG_VF = 4'hF;

    localparam logic [11:0] PC_RESET = 12'd512;
    localparam logic [11:0] PC_STEP  = 12'd2;

    // Whole-word system opcodes.
    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    // Low-byte selectors of the Ex and Fx groups.
    localparam logic [7:0] KK_SKP      = 8'h9E;
    localparam logic [7:0] KK_SKNP     = 8'hA1;
    localparam logic [7:0] KK_LD_VX_DT = 8'h07;
    localparam logic [7:0] KK_LD_DT    = 8'h15;
    localparam logic [7:0] KK_LD_ST    = 8'h18;
    localparam logic [7:0] KK_ADD_I    = 8'h1E;

    typedef enum logic [3:0] {
        OP_SYS     = 4'h0,
        OP_JP      = 4'h1,
        OP_CALL    = 4'h2,
        OP_SE_IMM  = 4'h3,
        OP_SNE_IMM = 4'h4,
        OP_SE_REG  = 4'h5,
        OP_LD_IMM  = 4'h6,
        OP_ADD_IMM = 4'h7,
        OP_ALU     = 4'h8,
        OP_SNE_REG = 4'h9,
        OP_LD_I    = 4'hA,
        OP_JP_V0   = 4'hB,
        OP_RND     = 4'hC,
        OP_DRW     = 4'hD,
        OP_SKEY    = 4'hE,
        OP_MISC    = 4'hF
    } op_major_t;

    typedef enum logic [3:0] {
        ALU_LD   = 4'h0,
        ALU_OR   = 4'h1,
        ALU_AND  = 4'h2,
        ALU_XOR  = 4'h3,
        ALU_ADD  = 4'h4,
        ALU_SUB  = 4'h5,
        ALU_SHR  = 4'h6,
        ALU_SUBN = 4'h7,
        ALU_SHL  = 4'hE
    } alu_op_t;

    typedef enum logic [1:0] {
        REQ_NONE  = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_DRAW  = 2'd2
    } req_t;

    typedef struct packed {
        logic       wr_x;
        logic [7:0] value;
        logic       wr_f;
        logic       flag;
    } alu_res_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] opcode;
        logic [15:0] keys_down;
        logic [7:0]  random_byte;
        logic        collision;
    } in_item_t;

    typedef struct packed {
        logic [11:0] next_pc;
        logic [15:0] index_value;
        req_t        display_request;
        logic [7:0]  draw_x;
        logic [7:0]  draw_y;
        logic [3:0]  draw_rows;
        logic        sound_active;
        logic        stack_fault;
    } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/c8ie_in_if.sv
// ============================================================================
// c8ie_in_if: input channel of the CHIP-8 execute unit
// Valid/ready channel that carries one opcode or collision beat.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface c8ie_in_if;
    logic               valid;
    logic               ready;
    c8ie_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/c8ie_out_if.sv
// ============================================================================
// c8ie_out_if: result channel of the CHIP-8 execute unit
// Valid/ready channel that carries one result beat per executed item.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface c8ie_out_if;
    logic                valid;
    logic                ready;
    c8ie_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/c8ie_cfg_if.sv
// ============================================================================
// c8ie_cfg_if: configuration write channel of the CHIP-8 execute unit
// Valid/ready channel that carries the program start address.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface c8ie_cfg_if;
    logic        valid;
    logic        ready;
    logic [11:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/chip8_instruction_execute.sv
// ============================================================================
// chip8_instruction_execute: CHIP-8 opcode execute unit
// Holds V0..VF, I, PC, the timers and the return stack, executes one opcode
// or collision report per beat and issues clear and draw requests.
// ============================================================================
// Beats pass the execute stage register, then the result register, at one beat
// per cycle unless the result channel stalls. The register file and return stack
// are read in the accept cycle with bypass from the instruction executing alongside.
// Reset clears V0..VF, I, the timers and the stack level and sets PC to 512.
// The return stack entries are not cleared; only written entries are read.
`timescale 1ns / 1ps
`default_nettype none

module chip8_instruction_execute (
    input  wire logic       clk,
    input  wire logic       rst_n,
    c8ie_in_if.sink         item,
    c8ie_out_if.source      result,
    c8ie_cfg_if.sink        cfg
);

    // ------------------------------------------------------------------------
    // Architectural state. V0..VE live in a small RAM with per-entry valid
    // bits, so an entry never written reads as zero. VF sits in a flop of its
    // own because the ALU writes it in the same cycle as Vx, and V0 has a
    // shadow flop so that Bnnn does not need a third read port.
    // ------------------------------------------------------------------------
    logic [7:0]                 gr_mem [c8ie_pkg::NUM_REGS];
    logic [c8ie_pkg::NUM_REGS-1:0] gr_vld_reg;
    logic [7:0]                 vf_reg;
    logic [7:0]                 v0_reg;
    logic [15:0]                index_reg;
    logic [11:0]                pc_reg;
    logic [7:0]                 delay_reg;
    logic [7:0]                 sound_reg;
    logic [11:0]                stk_mem [c8ie_pkg::STACK_DEPTH];
    c8ie_pkg::stk_lvl_t         stk_lvl_reg;

    // Execute stage input register and the operands read in the accept cycle.
    logic                       s1_vld_reg;
    c8ie_pkg::in_item_t         s1_item_reg;
    logic [7:0]                 vx_raw_reg;
    logic [7:0]                 vy_raw_reg;
    logic                       vx_byp_reg;
    logic                       vy_byp_reg;
    logic [7:0]                 vx_byp_val_reg;
    logic [7:0]                 vy_byp_val_reg;
    logic [11:0]                stk_top_reg;
    logic                       stk_byp_reg;
    logic [11:0]                stk_byp_val_reg;

    // Result register.
    logic                       out_vld_reg;
    c8ie_pkg::out_item_t        out_data_reg;

    // Handshakes.
    logic in_fire;
    logic exec_fire;
    logic cfg_fire;

    assign exec_fire   = s1_vld_reg && (!out_vld_reg || result.ready);
    assign item.ready  = !s1_vld_reg || exec_fire;
    assign in_fire     = item.valid && item.ready;
    assign cfg.ready   = 1'b1;
    assign cfg_fire    = cfg.valid;
    assign result.valid = out_vld_reg;
    assign result.data  = out_data_reg;

    // ------------------------------------------------------------------------
    // Execute stage
    // ------------------------------------------------------------------------
    logic [3:0]          ex_x;
    logic [3:0]          ex_n;
    logic [7:0]          ex_kk;
    logic [11:0]         ex_nnn;
    logic [7:0]          vx;
    logic [7:0]          vy;
    logic [11:0]         ret_addr;
    logic [11:0]         pc_adv;
    c8ie_pkg::alu_res_t  alu_res;

    assign ex_x     = s1_item_reg.opcode[11:8];
    assign ex_n     = s1_item_reg.opcode[3:0];
    assign ex_kk    = s1_item_reg.opcode[7:0];
    assign ex_nnn   = s1_item_reg.opcode[11:0];
    assign vx       = vx_byp_reg ? vx_byp_val_reg : vx_raw_reg;
    assign vy       = vy_byp_reg ? vy_byp_val_reg : vy_raw_reg;
    assign ret_addr = stk_byp_reg ? stk_byp_val_reg : stk_top_reg;
    assign pc_adv   = pc_reg + c8ie_pkg::PC_STEP;

    c8ie_alu u_alu (
        .op  (c8ie_pkg::alu_op_t'(ex_n)),
        .a   (vx),
        .b   (vy),
        .res (alu_res)
    );

    logic                pressed;
    logic                skip;
    logic [11:0]         pc_next;
    logic [15:0]         index_next;
    logic [7:0]          delay_next;
    logic [7:0]          sound_next;
    c8ie_pkg::stk_lvl_t  lvl_next;
    logic                push;
    logic                wr_x;
    logic [7:0]          wr_x_data;
    logic                wr_f;
    logic [7:0]          wr_f_data;
    c8ie_pkg::req_t      req;
    logic [7:0]          draw_x;
    logic [7:0]          draw_y;
    logic [3:0]          draw_rows;
    logic                fault;

    // A key number above F can never be pressed.
    assign pressed = (vx[7:4] == 4'h0) && s1_item_reg.keys_down[vx[3:0]];

    always_comb
    begin
        pc_next    = pc_reg;
        index_next = index_reg;
        delay_next = delay_reg;
        sound_next = sound_reg;
        lvl_next   = stk_lvl_reg;
        push       = 1'b0;
        wr_x       = 1'b0;
        wr_x_data  = ex_kk;
        wr_f       = 1'b0;
        wr_f_data  = 8'h00;
        req        = c8ie_pkg::REQ_NONE;
        draw_x     = 8'h00;
        draw_y     = 8'h00;
        draw_rows  = 4'h0;
        fault      = 1'b0;
        skip       = 1'b0;

        if (s1_item_reg.kind)
        begin
            // Collision report from the display unit: only VF changes.
            wr_f      = 1'b1;
            wr_f_data = {7'b0, s1_item_reg.collision};
        end
        else
        begin
            pc_next = pc_adv;
            unique case (c8ie_pkg::op_major_t'(s1_item_reg.opcode[15:12]))
                c8ie_pkg::OP_SYS:
                begin
                    if (s1_item_reg.opcode == c8ie_pkg::OPC_CLS)
                    begin
                        req = c8ie_pkg::REQ_CLEAR;
                    end
                    else if (s1_item_reg.opcode == c8ie_pkg::OPC_RET)
                    begin
                        if (stk_lvl_reg == '0)
                        begin
                            fault = 1'b1;
                        end
                        else
                        begin
                            lvl_next = stk_lvl_reg - 1'b1;
                            pc_next  = ret_addr;
                        end
                    end
                end
                c8ie_pkg::OP_JP:
                begin
                    pc_next = ex_nnn;
                end
                c8ie_pkg::OP_CALL:
                begin
                    if (stk_lvl_reg >= c8ie_pkg::stk_lvl_t'(c8ie_pkg::STACK_DEPTH))
                    begin
                        fault = 1'b1;
                    end
                    else
                    begin
                        push     = 1'b1;
                        lvl_next = stk_lvl_reg + 1'b1;
                        pc_next  = ex_nnn;
                    end
                end
                c8ie_pkg::OP_SE_IMM:
                begin
                    skip = (vx == ex_kk);
                end
                c8ie_pkg::OP_SNE_IMM:
                begin
                    skip = (vx != ex_kk);
                end
                c8ie_pkg::OP_SE_REG:
                begin
                    skip = (vx == vy);
                end
                c8ie_pkg::OP_LD_IMM:
                begin
                    wr_x      = 1'b1;
                    wr_x_data = ex_kk;
                end
                c8ie_pkg::OP_ADD_IMM:
                begin
                    wr_x      = 1'b1;
                    wr_x_data = vx + ex_kk;
                end
                c8ie_pkg::OP_ALU:
                begin
                    wr_x      = alu_res.wr_x;
                    wr_x_data = alu_res.value;
                    wr_f      = alu_res.wr_f;
                    wr_f_data = {7'b0, alu_res.flag};
                end
                c8ie_pkg::OP_SNE_REG:
                begin
                    skip = (vx != vy);
                end
                c8ie_pkg::OP_LD_I:
                begin
                    index_next = {4'h0, ex_nnn};
                end
                c8ie_pkg::OP_JP_V0:
                begin
                    pc_next = ex_nnn + {4'h0, v0_reg};
                end
                c8ie_pkg::OP_RND:
                begin
                    wr_x      = 1'b1;
                    wr_x_data = s1_item_reg.random_byte & ex_kk;
                end
                c8ie_pkg::OP_DRW:
                begin
                    req       = c8ie_pkg::REQ_DRAW;
                    draw_x    = vx;
                    draw_y    = vy;
                    draw_rows = ex_n;
                end
                c8ie_pkg::OP_SKEY:
                begin
                    if (ex_kk == c8ie_pkg::KK_SKP)
                    begin
                        skip = pressed;
                    end
                    else if (ex_kk == c8ie_pkg::KK_SKNP)
                    begin
                        skip = !pressed;
                    end
                end
                c8ie_pkg::OP_MISC:
                begin
                    // Memory operations of this group fall through and only advance PC.
                    case (ex_kk)
                        c8ie_pkg::KK_LD_VX_DT:
                        begin
                            wr_x      = 1'b1;
                            wr_x_data = delay_reg;
                        end
                        c8ie_pkg::KK_LD_DT:  delay_next = vx;
                        c8ie_pkg::KK_LD_ST:  sound_next = vx;
                        c8ie_pkg::KK_ADD_I:  index_next = index_reg + {8'h00, vx};
                        default:             index_next = index_reg;
                    endcase
                end
            endcase
            if (skip)
            begin
                pc_next = pc_next + c8ie_pkg::PC_STEP;
            end
        end
    end

    // Write enables, qualified by the execute handshake. A write of Vx with x
    // equal to F lands in the VF flop, and an ALU flag write takes precedence.
    logic                x_we;
    logic                vf_we;
    logic [7:0]          vf_wdata;
    logic [7:0]          vf_after;
    logic                push_we;
    c8ie_pkg::stk_lvl_t  lvl_after;

    assign x_we      = exec_fire && wr_x && (ex_x != c8ie_pkg::REG_VF);
    assign vf_we     = exec_fire && (wr_f || (wr_x && (ex_x == c8ie_pkg::REG_VF)));
    assign vf_wdata  = wr_f ? wr_f_data : wr_x_data;
    assign vf_after  = vf_we ? vf_wdata : vf_reg;
    assign push_we   = exec_fire && push;
    assign lvl_after = exec_fire ? lvl_next : stk_lvl_reg;

    // ------------------------------------------------------------------------
    // Operand read for the beat being accepted. The RAM read is registered;
    // VF, the write of the instruction executing this cycle and never-written
    // entries are resolved into a bypass value captured next to it.
    // ------------------------------------------------------------------------
    logic [3:0]          rd_x;
    logic [3:0]          rd_y;
    logic                rd_x_byp;
    logic                rd_y_byp;
    logic [7:0]          rd_x_val;
    logic [7:0]          rd_y_val;
    c8ie_pkg::stk_lvl_t  lvl_dec;
    c8ie_pkg::stk_idx_t  stk_rd_idx;

    assign rd_x = item.data.opcode[11:8];
    assign rd_y = item.data.opcode[7:4];

    always_comb
    begin
        rd_x_byp = 1'b1;
        rd_x_val = 8'h00;
        if (rd_x == c8ie_pkg::REG_VF)
        begin
            rd_x_val = vf_after;
        end
        else if (x_we && (rd_x == ex_x))
        begin
            rd_x_val = wr_x_data;
        end
        else if (gr_vld_reg[rd_x])
        begin
            rd_x_byp = 1'b0;
        end

        rd_y_byp = 1'b1;
        rd_y_val = 8'h00;
        if (rd_y == c8ie_pkg::REG_VF)
        begin
            rd_y_val = vf_after;
        end
        else if (x_we && (rd_y == ex_x))
        begin
            rd_y_val = wr_x_data;
        end
        else if (gr_vld_reg[rd_y])
        begin
            rd_y_byp = 1'b0;
        end
    end

    // The top of stack after this cycle sits one below the new level. A push
    // this cycle writes exactly that entry, so its data is bypassed.
    assign lvl_dec    = lvl_after - 1'b1;
    assign stk_rd_idx = (lvl_after == '0) ? '0 : lvl_dec[c8ie_pkg::STK_IDX_W-1:0];

    // ------------------------------------------------------------------------
    // Storage arrays and payload registers (no reset).
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (x_we)
        begin
            gr_mem[ex_x] <= wr_x_data;
        end
        if (push_we)
        begin
            stk_mem[stk_lvl_reg[c8ie_pkg::STK_IDX_W-1:0]] <= pc_adv;
        end
        if (in_fire)
        begin
            s1_item_reg     <= item.data;
            vx_raw_reg      <= gr_mem[rd_x];
            vy_raw_reg      <= gr_mem[rd_y];
            vx_byp_reg      <= rd_x_byp;
            vy_byp_reg      <= rd_y_byp;
            vx_byp_val_reg  <= rd_x_val;
            vy_byp_val_reg  <= rd_y_val;
            stk_top_reg     <= stk_mem[stk_rd_idx];
            stk_byp_reg     <= push_we;
            stk_byp_val_reg <= pc_adv;
        end
        if (exec_fire)
        begin
            out_data_reg.next_pc         <= pc_next;
            out_data_reg.index_value     <= index_next;
            out_data_reg.display_request <= req;
            out_data_reg.draw_x          <= draw_x;
            out_data_reg.draw_y          <= draw_y;
            out_data_reg.draw_rows       <= draw_rows;
            out_data_reg.sound_active    <= (sound_next != 8'h00);
            out_data_reg.stack_fault     <= fault;
        end
    end

    // ------------------------------------------------------------------------
    // Architectural and control state (asynchronous reset).
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gr_vld_reg  <= '0;
            vf_reg      <= 8'h00;
            v0_reg      <= 8'h00;
            index_reg   <= 16'h0000;
            pc_reg      <= c8ie_pkg::PC_RESET;
            delay_reg   <= 8'h00;
            sound_reg   <= 8'h00;
            stk_lvl_reg <= '0;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (exec_fire)
            begin
                s1_vld_reg <= 1'b0;
            end

            if (exec_fire)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            if (x_we)
            begin
                gr_vld_reg[ex_x] <= 1'b1;
                if (ex_x == c8ie_pkg::REG_V0)
                begin
                    v0_reg <= wr_x_data;
                end
            end
            if (vf_we)
            begin
                vf_reg <= vf_wdata;
            end

            if (cfg_fire)
            begin
                pc_reg <= cfg.data;
            end
            else if (exec_fire)
            begin
                pc_reg <= pc_next;
            end

            if (exec_fire)
            begin
                index_reg   <= index_next;
                delay_reg   <= delay_next;
                sound_reg   <= sound_next;
                stk_lvl_reg <= lvl_next;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_stk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stk_lvl_reg <= c8ie_pkg::stk_lvl_t'(c8ie_pkg::STACK_DEPTH))
        else $error("return stack level beyond its depth");

    a_push_level: assert property (@(posedge clk) disable iff (!rst_n)
        push_we |=> (stk_lvl_reg == $past(stk_lvl_reg) + 1'b1))
        else $error("call did not raise the stack level by one");

    a_fault_no_req: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.stack_fault)
            |-> (result.data.display_request == c8ie_pkg::REQ_NONE))
        else $error("stack fault beat carries a display request");

    a_coll_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && s1_item_reg.kind && !cfg_fire)
            |=> (result.data.next_pc == $past(pc_reg)))
        else $error("collision report moved the program counter");

endmodule

`default_nettype wire

FILE: hw/rtl/c8ie_alu.sv
// ============================================================================
// c8ie_alu: register-to-register ALU group (8xyn opcodes)
// Computes the Vx result and the VF flag from the old register values.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module c8ie_alu (
    input  wire c8ie_pkg::alu_op_t  op,
    input  wire logic [7:0]         a,
    input  wire logic [7:0]         b,
    output c8ie_pkg::alu_res_t      res
);

    logic [8:0] sum;

    assign sum = {1'b0, a} + {1'b0, b};

    always_comb
    begin
        res = '0;
        unique case (op)
            c8ie_pkg::ALU_LD:
            begin
                res.wr_x  = 1'b1;
                res.value = b;
            end
            c8ie_pkg::ALU_OR:
            begin
                res.wr_x  = 1'b1;
                res.value = a | b;
            end
            c8ie_pkg::ALU_AND:
            begin
                res.wr_x  = 1'b1;
                res.value = a & b;
            end
            c8ie_pkg::ALU_XOR:
            begin
                res.wr_x  = 1'b1;
                res.value = a ^ b;
            end
            c8ie_pkg::ALU_ADD:
            begin
                res.wr_x  = 1'b1;
                res.value = sum[7:0];
                res.wr_f  = 1'b1;
                res.flag  = sum[8];
            end
            c8ie_pkg::ALU_SUB:
            begin
                res.wr_x  = 1'b1;
                res.value = a - b;
                res.wr_f  = 1'b1;
                res.flag  = (a > b);
            end
            c8ie_pkg::ALU_SHR:
            begin
                res.wr_x  = 1'b1;
                res.value = {1'b0, a[7:1]};
                res.wr_f  = 1'b1;
                res.flag  = a[0];
            end
            c8ie_pkg::ALU_SUBN:
            begin
                res.wr_x  = 1'b1;
                res.value = b - a;
                res.wr_f  = 1'b1;
                res.flag  = (b > a);
            end
            c8ie_pkg::ALU_SHL:
            begin
                res.wr_x  = 1'b1;
                res.value = {a[6:0], 1'b0};
                res.wr_f  = 1'b1;
                res.flag  = a[7];
            end
            default:
            begin
                // Undefined ALU codes leave every register alone.
                res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire
